// ----- rtl/kgmc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// kgmc_pkg
// Shared item types, codes and helpers for the k-mer guide match counter.
// ============================================================================
package kgmc_pkg;

    localparam int MODE_W  = 2;
    localparam int BASE_W  = 3;
    localparam int SLOT_W  = 10;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 32;
    localparam int GLEN_W  = 6;
    localparam int CLEAN_W = 6;

    localparam logic [GLEN_W-1:0]  GLEN_RESET = 6'd20;
    localparam logic [CLEAN_W-1:0] CLEAN_MAX  = 6'd63;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 32'hFFFF_FFFF;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic RES_READ  = 1'b0;
    localparam logic RES_QUERY = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BASE_W-1:0] base;
        logic              last_base;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  guide_key;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic              mapped;
        logic [SLOT_W-1:0] matched_slot;
        logic [CNT_W-1:0]  count_value;
        logic [CNT_W-1:0]  read_count;
        logic [CNT_W-1:0]  unmapped_count;
    } t_out_item;

    // token kinds moving down the cell chain
    typedef enum logic [1:0] {
        TK_SCAN   = 2'd0,
        TK_LOAD   = 2'd1,
        TK_UPDATE = 2'd2,
        TK_QUERY  = 2'd3
    } t_tok_kind;

    typedef struct packed {
        logic      valid;
        t_tok_kind kind;
        logic      hit;
    } t_tok_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/kgmc_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// kgmc_cell
// One chain cell: holds one bank of guide keys and counts (slots whose low
// index bits equal CELL_ID), serves tokens and passes them on via r_b and r_o.
// ============================================================================
module kgmc_cell
    import kgmc_pkg::*;
#(
    parameter int CELL_ID   = 0,
    parameter int CELL_BITS = 3,
    parameter int ROWS      = 128,
    parameter int ROW_W     = 7,
    parameter int WIN_W     = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr_en,
    input  logic [ROW_W-1:0]     i_clr_row,
    input  logic [WIN_W-1:0]     i_mask,
    input  t_tok_ctl             i_ctl,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [CELL_BITS-1:0] i_cell,
    input  logic [WIN_W-1:0]     i_word,
    input  logic [CNT_W-1:0]     i_cnt,
    output t_tok_ctl             o_ctl,
    output logic [ROW_W-1:0]     o_row,
    output logic [CELL_BITS-1:0] o_cell,
    output logic [WIN_W-1:0]     o_word,
    output logic [CNT_W-1:0]     o_cnt
);

    localparam logic [CELL_BITS-1:0] MY_ID = CELL_BITS'(CELL_ID);

    logic [WIN_W-1:0] r_key_mem [ROWS];
    logic [CNT_W:0]   r_cnt_mem [ROWS];   // {valid, count}

    logic [WIN_W-1:0] r_key_rd;
    logic [CNT_W:0]   r_cnt_rd;

    t_tok_ctl             r_b_ctl;
    logic [ROW_W-1:0]     r_b_row;
    logic [CELL_BITS-1:0] r_b_cell;
    logic [WIN_W-1:0]     r_b_word;
    logic [CNT_W-1:0]     r_b_cnt;

    t_tok_ctl             r_o_ctl;
    logic [ROW_W-1:0]     r_o_row;
    logic [CELL_BITS-1:0] r_o_cell;
    logic [WIN_W-1:0]     r_o_word;
    logic [CNT_W-1:0]     r_o_cnt;

    t_tok_ctl             n_o_ctl;
    logic [CELL_BITS-1:0] n_o_cell;
    logic [CNT_W-1:0]     n_o_cnt;

    logic             mine;
    logic             wr_key;
    logic             wr_cnt;
    logic [CNT_W-1:0] wr_cnt_val;
    logic             hit_here;

    assign mine       = i_ctl.valid && (i_cell == MY_ID);
    assign wr_key     = mine && (i_ctl.kind == TK_LOAD);
    assign wr_cnt     = mine && ((i_ctl.kind == TK_LOAD) || (i_ctl.kind == TK_UPDATE));
    assign wr_cnt_val = (i_ctl.kind == TK_LOAD) ? '0 : i_cnt;

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            r_cnt_mem[i_clr_row] <= '0;
        end else if (wr_cnt) begin
            r_cnt_mem[i_row] <= {1'b1, wr_cnt_val};
        end
        if (wr_key) begin
            r_key_mem[i_row] <= i_word;
        end
        r_key_rd <= r_key_mem[i_row];
        r_cnt_rd <= r_cnt_mem[i_row];
    end

    assign hit_here = r_b_ctl.valid && (r_b_ctl.kind == TK_SCAN) && !r_b_ctl.hit &&
                      r_cnt_rd[CNT_W] && ((r_key_rd & i_mask) == r_b_word);

    always_comb begin
        n_o_ctl  = r_b_ctl;
        n_o_cell = r_b_cell;
        n_o_cnt  = r_b_cnt;
        if (hit_here) begin
            n_o_ctl.hit = 1'b1;
            n_o_cell    = MY_ID;
            n_o_cnt     = r_cnt_rd[CNT_W-1:0];
        end
        if (r_b_ctl.valid && (r_b_ctl.kind == TK_QUERY) && (r_b_cell == MY_ID)) begin
            n_o_cnt = r_cnt_rd[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
            r_o_ctl <= '0;
        end else begin
            r_b_ctl <= i_ctl;
            r_o_ctl <= n_o_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_row  <= i_row;
        r_b_cell <= i_cell;
        r_b_word <= i_word;
        r_b_cnt  <= i_cnt;
        r_o_row  <= r_b_row;
        r_o_cell <= n_o_cell;
        r_o_word <= r_b_word;
        r_o_cnt  <= n_o_cnt;
    end

    assign o_ctl  = r_o_ctl;
    assign o_row  = r_o_row;
    assign o_cell = r_o_cell;
    assign o_word = r_o_word;
    assign o_cnt  = r_o_cnt;

endmodule

// ----- rtl/kmer_guide_match_counter_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// kmer_guide_match_counter_unit
// Exact k-mer window match counter over a loaded guide table.
// ============================================================================
// The guide table is split over a chain of 2**CELL_BITS cells; slot s lives in
// cell s mod cells, row s / cells. After reset a clearing pass over all
// ceil(TABLE_DEPTH / cells) rows (128 by default) runs before the first item
// is taken; configuration writes are taken at any time. A guide load sends one
// load token down the chain and stays idle. A read base with no table search
// due stays idle, or moves to the report state when it also ends the read;
// otherwise the block sweeps the table one row per cycle through the chain,
// stopping at the first row with a hit; tokens pass each cell's r_b and r_o
// registers. A count query sends one token down the chain and waits for its
// return. Results wait in an output register while the next item is taken; a
// second result stalls the input until the first is accepted.
module kmer_guide_match_counter_unit
    import kgmc_pkg::*;
#(
    parameter int TABLE_DEPTH     = 1024,
    parameter int MAX_GUIDE_BASES = 32,
    parameter int CELL_BITS       = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [GLEN_W-1:0] i_cfg_data
);

    localparam int NUM_CELLS = 1 << CELL_BITS;
    localparam int ROWS      = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RC_W      = $clog2(ROWS + 1);
    localparam int IDX_W     = ROW_W + CELL_BITS;
    localparam int WIN_W     = 2 * MAX_GUIDE_BASES;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_QUERY  = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [GLEN_W-1:0]    r_glen, n_glen;
    logic [WIN_W-1:0]     r_win, n_win;
    logic [CLEAN_W-1:0]   r_clean, n_clean;
    logic                 r_matched, n_matched;
    logic [SLOT_W-1:0]    r_hit_slot, n_hit_slot;
    logic [CNT_W-1:0]     r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0]     r_read_total, n_read_total;
    logic [CNT_W-1:0]     r_unmapped_total, n_unmapped_total;
    logic                 r_last, n_last;
    logic [WIN_W-1:0]     r_scan_word, n_scan_word;
    logic [RC_W-1:0]      r_issued, n_issued;
    logic [RC_W-1:0]      r_returned, n_returned;
    logic                 r_found, n_found;
    logic [ROW_W-1:0]     r_f_row, n_f_row;
    logic [CELL_BITS-1:0] r_f_cell, n_f_cell;
    logic [CNT_W-1:0]     r_f_cnt, n_f_cnt;
    logic                 r_res_kind, n_res_kind;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [CNT_W-1:0]     r_res_cnt, n_res_cnt;
    logic [ROW_W-1:0]     r_clr_row, n_clr_row;
    t_tok_ctl             r_tok_ctl, n_tok_ctl;
    logic [ROW_W-1:0]     r_tok_row, n_tok_row;
    logic [CELL_BITS-1:0] r_tok_cell, n_tok_cell;
    logic [WIN_W-1:0]     r_tok_word, n_tok_word;
    logic [CNT_W-1:0]     r_tok_cnt, n_tok_cnt;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data, n_out_data;

    t_tok_ctl             ch_ctl  [NUM_CELLS+1];
    logic [ROW_W-1:0]     ch_row  [NUM_CELLS+1];
    logic [CELL_BITS-1:0] ch_cell [NUM_CELLS+1];
    logic [WIN_W-1:0]     ch_word [NUM_CELLS+1];
    logic [CNT_W-1:0]     ch_cnt  [NUM_CELLS+1];

    logic [GLEN_W-1:0]       win_n;
    logic [WIN_W-1:0]        mask;
    logic                    in_acc;
    logic                    out_free;
    logic [IDX_W+SLOT_W-1:0] in_slot_wide;
    logic [CELL_BITS-1:0]    in_cell;
    logic [ROW_W-1:0]        in_row;
    logic                    in_range;
    logic                    base_ok;
    logic [WIN_W-1:0]        nxt_win;
    logic [CLEAN_W-1:0]      nxt_clean;
    logic [IDX_W+SLOT_W-1:0] f_slot_wide;
    logic                    scan_done;
    logic [CNT_W-1:0]        rep_total;
    logic [CNT_W-1:0]        rep_unmapped;
    t_tok_ctl                tail_ctl;

    // window length, clamped to 1..MAX_GUIDE_BASES
    assign win_n = (r_glen == '0) ? GLEN_W'(1) :
                   (r_glen > GLEN_W'(MAX_GUIDE_BASES)) ? GLEN_W'(MAX_GUIDE_BASES) : r_glen;

    always_comb begin
        for (int i = 0; i < WIN_W; i++) begin
            mask[i] = (i < 2 * int'(win_n));
        end
    end

    assign in_acc       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign in_slot_wide = {{IDX_W{1'b0}}, i_in_data.slot};
    assign in_cell      = in_slot_wide[CELL_BITS-1:0];
    assign in_row       = in_slot_wide[CELL_BITS +: ROW_W];
    assign in_range     = 32'(i_in_data.slot) < 32'(TABLE_DEPTH);
    assign base_ok      = !i_in_data.base[BASE_W-1];
    assign nxt_win      = (r_win << 2) | WIN_W'(i_in_data.base[1:0]);
    assign nxt_clean    = !base_ok ? '0 :
                          (r_clean == CLEAN_MAX) ? r_clean : r_clean + 1'b1;
    assign f_slot_wide  = {{SLOT_W{1'b0}}, r_f_row, r_f_cell};
    assign scan_done    = (r_returned == r_issued) &&
                          (r_found || (r_issued == RC_W'(ROWS)));
    assign rep_total    = sat_inc(r_read_total);
    assign rep_unmapped = r_matched ? r_unmapped_total : sat_inc(r_unmapped_total);
    assign tail_ctl     = ch_ctl[NUM_CELLS];

    always_comb begin
        n_state          = r_state;
        n_glen           = r_glen;
        n_win            = r_win;
        n_clean          = r_clean;
        n_matched        = r_matched;
        n_hit_slot       = r_hit_slot;
        n_hit_cnt        = r_hit_cnt;
        n_read_total     = r_read_total;
        n_unmapped_total = r_unmapped_total;
        n_last           = r_last;
        n_scan_word      = r_scan_word;
        n_issued         = r_issued;
        n_returned       = r_returned;
        n_found          = r_found;
        n_f_row          = r_f_row;
        n_f_cell         = r_f_cell;
        n_f_cnt          = r_f_cnt;
        n_res_kind       = r_res_kind;
        n_res_slot       = r_res_slot;
        n_res_cnt        = r_res_cnt;
        n_clr_row        = r_clr_row;
        n_tok_ctl        = '0;
        n_tok_row        = r_tok_row;
        n_tok_cell       = r_tok_cell;
        n_tok_word       = r_tok_word;
        n_tok_cnt        = r_tok_cnt;
        n_out_valid      = r_out_valid && !i_out_ready;
        n_out_data       = r_out_data;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_data.last_base;
                    unique case (i_in_data.mode)
                        MODE_LOAD: begin
                            if (in_range) begin
                                n_tok_ctl.valid = 1'b1;
                                n_tok_ctl.kind  = TK_LOAD;
                                n_tok_row       = in_row;
                                n_tok_cell      = in_cell;
                                n_tok_word      = i_in_data.guide_key[WIN_W-1:0];
                                n_tok_cnt       = '0;
                                if (r_matched && (i_in_data.slot == r_hit_slot)) begin
                                    n_hit_cnt = '0;
                                end
                            end
                        end
                        MODE_QUERY: begin
                            n_res_kind = RES_QUERY;
                            n_res_slot = i_in_data.slot;
                            if (in_range) begin
                                n_tok_ctl.valid = 1'b1;
                                n_tok_ctl.kind  = TK_QUERY;
                                n_tok_row       = in_row;
                                n_tok_cell      = in_cell;
                                n_tok_cnt       = '0;
                                n_state         = S_QUERY;
                            end else begin
                                n_res_cnt = '0;
                                n_state   = S_REPORT;
                            end
                        end
                        MODE_BASE: begin
                            n_win      = nxt_win;
                            n_clean    = nxt_clean;
                            n_res_kind = RES_READ;
                            if (!r_matched && (nxt_clean >= win_n)) begin
                                n_scan_word = nxt_win & mask;
                                n_issued    = '0;
                                n_returned  = '0;
                                n_found     = 1'b0;
                                n_state     = S_SCAN;
                            end else if (i_in_data.last_base) begin
                                n_state = S_REPORT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_found && (r_issued != RC_W'(ROWS))) begin
                    n_tok_ctl.valid = 1'b1;
                    n_tok_ctl.kind  = TK_SCAN;
                    n_tok_row       = r_issued[ROW_W-1:0];
                    n_tok_cell      = '0;
                    n_tok_word      = r_scan_word;
                    n_tok_cnt       = '0;
                    n_issued        = r_issued + 1'b1;
                end
                if (tail_ctl.valid && (tail_ctl.kind == TK_SCAN)) begin
                    n_returned = r_returned + 1'b1;
                    if (tail_ctl.hit && !r_found) begin
                        n_found  = 1'b1;
                        n_f_row  = ch_row[NUM_CELLS];
                        n_f_cell = ch_cell[NUM_CELLS];
                        n_f_cnt  = ch_cnt[NUM_CELLS];
                    end
                end
                if (scan_done) begin
                    if (r_found) begin
                        n_tok_ctl.valid = 1'b1;
                        n_tok_ctl.kind  = TK_UPDATE;
                        n_tok_row       = r_f_row;
                        n_tok_cell      = r_f_cell;
                        n_tok_cnt       = sat_inc(r_f_cnt);
                        n_matched       = 1'b1;
                        n_hit_slot      = f_slot_wide[SLOT_W-1:0];
                        n_hit_cnt       = sat_inc(r_f_cnt);
                    end
                    n_state = r_last ? S_REPORT : S_IDLE;
                end
            end
            S_QUERY: begin
                if (tail_ctl.valid && (tail_ctl.kind == TK_QUERY)) begin
                    n_res_cnt = ch_cnt[NUM_CELLS];
                    n_state   = S_REPORT;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.result_kind  = r_res_kind;
                    if (r_res_kind == RES_QUERY) begin
                        n_out_data.mapped         = 1'b0;
                        n_out_data.matched_slot   = r_res_slot;
                        n_out_data.count_value    = r_res_cnt;
                        n_out_data.read_count     = r_read_total;
                        n_out_data.unmapped_count = r_unmapped_total;
                    end else begin
                        n_out_data.mapped         = r_matched;
                        n_out_data.matched_slot   = r_matched ? r_hit_slot : '0;
                        n_out_data.count_value    = r_matched ? r_hit_cnt : '0;
                        n_out_data.read_count     = rep_total;
                        n_out_data.unmapped_count = rep_unmapped;
                        n_read_total              = rep_total;
                        n_unmapped_total          = rep_unmapped;
                        n_win                     = '0;
                        n_clean                   = '0;
                        n_matched                 = 1'b0;
                        n_hit_slot                = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            n_glen = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_glen           <= GLEN_RESET;
            r_win            <= '0;
            r_clean          <= '0;
            r_matched        <= 1'b0;
            r_hit_slot       <= '0;
            r_read_total     <= '0;
            r_unmapped_total <= '0;
            r_issued         <= '0;
            r_returned       <= '0;
            r_found          <= 1'b0;
            r_clr_row        <= '0;
            r_tok_ctl        <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_glen           <= n_glen;
            r_win            <= n_win;
            r_clean          <= n_clean;
            r_matched        <= n_matched;
            r_hit_slot       <= n_hit_slot;
            r_read_total     <= n_read_total;
            r_unmapped_total <= n_unmapped_total;
            r_issued         <= n_issued;
            r_returned       <= n_returned;
            r_found          <= n_found;
            r_clr_row        <= n_clr_row;
            r_tok_ctl        <= n_tok_ctl;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_cnt   <= n_hit_cnt;
        r_last      <= n_last;
        r_scan_word <= n_scan_word;
        r_f_row     <= n_f_row;
        r_f_cell    <= n_f_cell;
        r_f_cnt     <= n_f_cnt;
        r_res_kind  <= n_res_kind;
        r_res_slot  <= n_res_slot;
        r_res_cnt   <= n_res_cnt;
        r_tok_row   <= n_tok_row;
        r_tok_cell  <= n_tok_cell;
        r_tok_word  <= n_tok_word;
        r_tok_cnt   <= n_tok_cnt;
        r_out_data  <= n_out_data;
    end

    assign ch_ctl[0]  = r_tok_ctl;
    assign ch_row[0]  = r_tok_row;
    assign ch_cell[0] = r_tok_cell;
    assign ch_word[0] = r_tok_word;
    assign ch_cnt[0]  = r_tok_cnt;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        kgmc_cell #(
            .CELL_ID   (g),
            .CELL_BITS (CELL_BITS),
            .ROWS      (ROWS),
            .ROW_W     (ROW_W),
            .WIN_W     (WIN_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr_en  (r_state == S_CLEAR),
            .i_clr_row (r_clr_row),
            .i_mask    (mask),
            .i_ctl     (ch_ctl[g]),
            .i_row     (ch_row[g]),
            .i_cell    (ch_cell[g]),
            .i_word    (ch_word[g]),
            .i_cnt     (ch_cnt[g]),
            .o_ctl     (ch_ctl[g+1]),
            .o_row     (ch_row[g+1]),
            .o_cell    (ch_cell[g+1]),
            .o_word    (ch_word[g+1]),
            .o_cnt     (ch_cnt[g+1])
        );
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // scan tokens are fully drained before the sweep ends
    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail_ctl.valid && (tail_ctl.kind == TK_SCAN)) |-> (r_state == S_SCAN))
        else $error("scan token left the chain outside a sweep");

    a_query_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail_ctl.valid && (tail_ctl.kind == TK_QUERY)) |-> (r_state == S_QUERY))
        else $error("query token left the chain with no query pending");

    a_return_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_returned <= r_issued)
        else $error("more scan rows returned than issued");

    a_read_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REPORT) && out_free && (r_res_kind == RES_READ))
        |=> (!r_matched && (r_clean == '0)))
        else $error("read state not cleared after end-of-read report");

endmodule
